[hw/rtl/rcr_pkg.sv]
// Shared types and constants for the rectangle canvas rasterizer.
`timescale 1ns / 1ps

package rcr_pkg;

    // Canvas geometry: pixel address is row * MAX_SIDE + col
    localparam int MAX_SIDE = 256;

    // Field widths
    localparam int COORD_W = 20;             // signed Q12.8 coordinate
    localparam int CELL_W  = COORD_W + 1 - 8; // integer part of an edge sum
    localparam int SIDE_W  = 9;              // canvas_width / canvas_height
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 8;              // read_row / read_col
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int QUEUE_DEPTH = 4;

    // Command codes
    localparam logic [1:0] CMD_DRAW  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Shape kinds
    localparam logic [7:0] KIND_OUTLINE = 8'h72;
    localparam logic [7:0] KIND_FILLED  = 8'h52;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_REJECT  = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;

    typedef enum logic [2:0] {
        JOB_NOP,
        JOB_DRAW,
        JOB_CLEAR,
        JOB_READ,
        JOB_REJECT
    } job_op_t;

    // Decoded command; cx/cy are the first and last covered column/row
    typedef struct packed {
        job_op_t                   op;
        logic                      filled;
        logic [CHAR_W-1:0]         color;
        logic signed [CELL_W-1:0]  cx0;
        logic signed [CELL_W-1:0]  cx1;
        logic signed [CELL_W-1:0]  cy0;
        logic signed [CELL_W-1:0]  cy1;
        logic [IDX_W-1:0]          read_row;
        logic [IDX_W-1:0]          read_col;
    } job_t;

    typedef struct packed {
        logic [SIDE_W-1:0] width;
        logic [SIDE_W-1:0] height;
        logic [CHAR_W-1:0] bg;
    } cfg_t;

    typedef struct packed {
        logic              error_seen;
        logic [CHAR_W-1:0] pixel_value;
        logic [1:0]        status;
    } result_t;

endpackage

[hw/rtl/rcr_front.sv]
// Front end: accepts commands, validates shapes and converts edges to pixel bounds.
`timescale 1ns / 1ps

module rcr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [103:0]         s_tdata,   // pos_x, pos_y, size_w, size_h, paint_char,
                                            // read_row, read_col
    input  logic [9:0]           s_tuser,   // cmd, shape_kind
    output logic                 push,
    output rcr_pkg::job_t        push_job,
    input  logic                 push_ready
);

    logic signed [rcr_pkg::COORD_W-1:0] pos_x;
    logic signed [rcr_pkg::COORD_W-1:0] pos_y;
    logic signed [rcr_pkg::COORD_W-1:0] size_w;
    logic signed [rcr_pkg::COORD_W-1:0] size_h;
    logic [1:0]                         cmd;
    logic [7:0]                         kind;
    logic signed [rcr_pkg::COORD_W:0]   x_lo;
    logic signed [rcr_pkg::COORD_W:0]   x_hi;
    logic signed [rcr_pkg::COORD_W:0]   y_lo;
    logic signed [rcr_pkg::COORD_W:0]   y_hi;
    logic                               shape_ok;
    rcr_pkg::job_t                      job;
    rcr_pkg::job_t                      stage_reg;
    logic                               stage_valid_reg;

    assign cmd    = s_tuser[1:0];
    assign kind   = s_tuser[9:2];
    assign pos_x  = s_tdata[19:0];
    assign pos_y  = s_tdata[39:20];
    assign size_w = s_tdata[59:40];
    assign size_h = s_tdata[79:60];

    // First covered cell is ceil(edge/256), last is floor((edge+size)/256)
    assign x_lo = (rcr_pkg::COORD_W+1)'(pos_x) + 21'sd255;
    assign x_hi = (rcr_pkg::COORD_W+1)'(pos_x) + (rcr_pkg::COORD_W+1)'(size_w);
    assign y_lo = (rcr_pkg::COORD_W+1)'(pos_y) + 21'sd255;
    assign y_hi = (rcr_pkg::COORD_W+1)'(pos_y) + (rcr_pkg::COORD_W+1)'(size_h);

    assign shape_ok = !size_w[rcr_pkg::COORD_W-1] && (size_w != '0)
                   && !size_h[rcr_pkg::COORD_W-1] && (size_h != '0)
                   && (kind == rcr_pkg::KIND_OUTLINE || kind == rcr_pkg::KIND_FILLED);

    always_comb
    begin
        job.filled   = (kind == rcr_pkg::KIND_FILLED);
        job.color    = s_tdata[87:80];
        job.cx0      = x_lo[rcr_pkg::COORD_W:8];
        job.cx1      = x_hi[rcr_pkg::COORD_W:8];
        job.cy0      = y_lo[rcr_pkg::COORD_W:8];
        job.cy1      = y_hi[rcr_pkg::COORD_W:8];
        job.read_row = s_tdata[95:88];
        job.read_col = s_tdata[103:96];
        unique case (cmd)
            rcr_pkg::CMD_DRAW:  job.op = shape_ok ? rcr_pkg::JOB_DRAW : rcr_pkg::JOB_REJECT;
            rcr_pkg::CMD_CLEAR: job.op = rcr_pkg::JOB_CLEAR;
            rcr_pkg::CMD_READ:  job.op = rcr_pkg::JOB_READ;
            default:            job.op = rcr_pkg::JOB_NOP;
        endcase
    end

    assign push     = stage_valid_reg && push_ready;
    assign push_job = stage_reg;
    assign s_tready = !stage_valid_reg || push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            stage_reg <= job;
        end
    end

endmodule

[hw/rtl/rcr_queue.sv]
// Short job queue between the front end and the canvas engine.
`timescale 1ns / 1ps

module rcr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rcr_pkg::job_t push_job,
    output logic          push_ready,
    input  logic          pop,
    output logic          head_valid,
    output rcr_pkg::job_t head_job
);

    localparam int PW = $clog2(rcr_pkg::QUEUE_DEPTH);

    rcr_pkg::job_t  entry_reg [rcr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    count_reg;

    assign push_ready = (count_reg != (PW+1)'(rcr_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/rcr_back.sv]
// Canvas engine: pixel walker, canvas memory, sticky error and result register.
`timescale 1ns / 1ps

module rcr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  rcr_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  rcr_pkg::job_t    q_job,
    output logic             q_pop,
    output logic             res_valid,
    output rcr_pkg::result_t res,
    input  logic             res_ready
);

    localparam int IW    = (rcr_pkg::MAX_SIDE > 1) ? $clog2(rcr_pkg::MAX_SIDE) : 1;
    localparam int DEPTH = rcr_pkg::MAX_SIDE * rcr_pkg::MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW  = ((IW > rcr_pkg::SIDE_W) ? IW : rcr_pkg::SIDE_W) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_READ
    } state_t;

    state_t                    state_reg;
    rcr_pkg::job_t             job_reg;
    logic [IW-1:0]             row_reg;
    logic [IW-1:0]             col_reg;
    logic [AW-1:0]             addr_reg;
    logic [AW-1:0]             base_reg;
    logic                      sticky_reg;
    logic                      res_valid_reg;
    rcr_pkg::result_t          res_reg;
    logic [rcr_pkg::CHAR_W-1:0] rd_data_reg;
    logic [rcr_pkg::CHAR_W-1:0] mem [DEPTH];

    logic signed [rcr_pkg::CELL_W:0] col_s;
    logic signed [rcr_pkg::CELL_W:0] row_s;
    logic                      in_rect;
    logic                      border;
    logic                      wr_en;
    logic [rcr_pkg::CHAR_W-1:0] wr_data;
    logic                      col_last;
    logic                      row_last;
    logic                      rd_in_range;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             base_step;

    assign col_s = signed'((rcr_pkg::CELL_W+1)'(col_reg));
    assign row_s = signed'((rcr_pkg::CELL_W+1)'(row_reg));

    assign in_rect = (col_s >= (rcr_pkg::CELL_W+1)'(job_reg.cx0))
                  && (col_s <= (rcr_pkg::CELL_W+1)'(job_reg.cx1))
                  && (row_s >= (rcr_pkg::CELL_W+1)'(job_reg.cy0))
                  && (row_s <= (rcr_pkg::CELL_W+1)'(job_reg.cy1));
    // Within one unit of an edge means sitting on the first or last covered cell
    assign border = (col_s == (rcr_pkg::CELL_W+1)'(job_reg.cx0))
                 || (col_s == (rcr_pkg::CELL_W+1)'(job_reg.cx1))
                 || (row_s == (rcr_pkg::CELL_W+1)'(job_reg.cy0))
                 || (row_s == (rcr_pkg::CELL_W+1)'(job_reg.cy1));

    assign wr_en = (state_reg == ST_WALK)
                && ((job_reg.op == rcr_pkg::JOB_CLEAR)
                 || ((job_reg.op == rcr_pkg::JOB_DRAW) && in_rect
                     && (job_reg.filled || border)));
    assign wr_data = (job_reg.op == rcr_pkg::JOB_CLEAR) ? cfg.bg : job_reg.color;

    assign col_last = (CMPW'(col_reg) + 1'b1) == CMPW'(cfg.width);
    assign row_last = (CMPW'(row_reg) + 1'b1) == CMPW'(cfg.height);

    assign q_pop = (state_reg == ST_IDLE) && q_valid && !res_valid_reg;

    assign rd_in_range = (rcr_pkg::SIDE_W'(q_job.read_row) < cfg.height)
                      && (rcr_pkg::SIDE_W'(q_job.read_col) < cfg.width);
    assign rd_en   = q_pop && (q_job.op == rcr_pkg::JOB_READ) && rd_in_range;
    assign rd_addr = AW'(q_job.read_row) * AW'(rcr_pkg::MAX_SIDE) + AW'(q_job.read_col);
    assign base_step = base_reg + AW'(rcr_pkg::MAX_SIDE);

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= '0;
            sticky_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            addr_reg      <= '0;
            base_reg      <= '0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        job_reg  <= q_job;
                        row_reg  <= '0;
                        col_reg  <= '0;
                        addr_reg <= '0;
                        base_reg <= '0;
                        case (q_job.op)
                            rcr_pkg::JOB_DRAW:
                            begin
                                state_reg <= ST_WALK;
                            end
                            rcr_pkg::JOB_CLEAR:
                            begin
                                sticky_reg <= 1'b0;
                                state_reg  <= ST_WALK;
                            end
                            rcr_pkg::JOB_READ:
                            begin
                                if (rd_in_range)
                                begin
                                    state_reg <= ST_READ;
                                end
                                else
                                begin
                                    res_valid_reg <= 1'b1;
                                    res_reg <= '{error_seen: sticky_reg, pixel_value: '0,
                                                 status: rcr_pkg::STATUS_OUTSIDE};
                                end
                            end
                            rcr_pkg::JOB_REJECT:
                            begin
                                sticky_reg    <= 1'b1;
                                res_valid_reg <= 1'b1;
                                res_reg <= '{error_seen: 1'b1, pixel_value: '0,
                                             status: rcr_pkg::STATUS_REJECT};
                            end
                            default:
                            begin
                                res_valid_reg <= 1'b1;
                                res_reg <= '{error_seen: sticky_reg, pixel_value: '0,
                                             status: rcr_pkg::STATUS_OK};
                            end
                        endcase
                    end
                end
                ST_WALK:
                begin
                    if (col_last)
                    begin
                        // advance to the start of the next row
                        col_reg  <= '0;
                        row_reg  <= row_reg + 1'b1;
                        base_reg <= base_step;
                        addr_reg <= base_step;
                        if (row_last)
                        begin
                            state_reg     <= ST_IDLE;
                            res_valid_reg <= 1'b1;
                            res_reg <= '{error_seen: sticky_reg, pixel_value: '0,
                                         status: rcr_pkg::STATUS_OK};
                        end
                    end
                    else
                    begin
                        col_reg  <= col_reg + 1'b1;
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_READ:
                begin
                    state_reg     <= ST_IDLE;
                    res_valid_reg <= 1'b1;
                    res_reg <= '{error_seen: sticky_reg, pixel_value: rd_data_reg,
                                 status: rcr_pkg::STATUS_OK};
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_walk_no_pending_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !res_valid_reg)
        else $error("result pending while walking the canvas");

    a_walk_row_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (CMPW'(row_reg) < CMPW'(cfg.height)))
        else $error("walker row beyond canvas height");

    a_read_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (res_valid_reg && state_reg == ST_IDLE))
        else $error("read did not produce a result");

    a_reject_sets_error: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status == rcr_pkg::STATUS_REJECT)
            |-> (res_reg.error_seen && sticky_reg))
        else $error("rejected shape without error flag");

endmodule

[hw/rtl/rectangle_canvas_rasterizer.sv]
// Top level of the rectangle canvas rasterizer: configuration registers and stream ports.
`timescale 1ns / 1ps

// Each command on the input stream returns exactly one result transaction, in order.
// A draw or clear walks the whole configured canvas one pixel per cycle through the
// single write port of the canvas memory. A read goes through the registered memory
// read port; a rejected shape, a read outside the canvas or an unused command returns
// its result with no walk and no memory read. The next command is not started until
// the previous result has been taken. The front end and a four-entry job queue keep
// accepting commands while a walk runs or a result waits to be taken, until full.
// The canvas memory is not cleared at reset: issue a clear before reading pixels.
// Configuration is written through cfg_*; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module rectangle_canvas_rasterizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [103:0]                      s_tdata,   // pos_x, pos_y, size_w, size_h,
                                                         // paint_char, read_row, read_col
    input  logic [9:0]                        s_tuser,   // cmd, shape_kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // status, pixel_value,
                                                         // error_seen, zero fill
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [rcr_pkg::SIDE_W-1:0] width_reg;
    logic [rcr_pkg::SIDE_W-1:0] height_reg;
    logic [rcr_pkg::CHAR_W-1:0] bg_reg;
    rcr_pkg::cfg_t              cfg;
    logic                       push;
    rcr_pkg::job_t              push_job;
    logic                       push_ready;
    logic                       q_pop;
    logic                       q_valid;
    rcr_pkg::job_t              q_job;
    logic                       res_valid;
    rcr_pkg::result_t           res;

    // Saturate a written side to 1..MAX_SIDE
    function automatic logic [rcr_pkg::SIDE_W-1:0] clamp_side(
        input logic [rcr_pkg::SIDE_W-1:0] v
    );
        logic [rcr_pkg::SIDE_W-1:0] r;
        if (v == '0)
        begin
            r = rcr_pkg::SIDE_W'(1);
        end
        else if (int'(v) > rcr_pkg::MAX_SIDE)
        begin
            r = rcr_pkg::SIDE_W'(rcr_pkg::MAX_SIDE);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= clamp_side(9'd256);
            height_reg <= clamp_side(9'd256);
            bg_reg     <= 8'd46;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rcr_pkg::CFG_WIDTH:  width_reg  <= clamp_side(cfg_data);
                rcr_pkg::CFG_HEIGHT: height_reg <= clamp_side(cfg_data);
                rcr_pkg::CFG_BG:     bg_reg     <= cfg_data[rcr_pkg::CHAR_W-1:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign cfg = '{width: width_reg, height: height_reg, bg: bg_reg};

    rcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    rcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_job)
    );

    rcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {5'b0, res.error_seen, res.pixel_value, res.status};

endmodule

[verif/rectangle_canvas_rasterizer_tb.sv]
// Self-checking testbench for the rectangle canvas rasterizer stream block.
`timescale 1ns / 1ps

module rectangle_canvas_rasterizer_tb;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam longint     ONE_Q       = 256;
    localparam int         SIDE        = rcr_pkg::MAX_SIDE;
    localparam int         HOLD_CYCLES = 400;
    localparam int         CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [1:0]                         cmd;
        logic [7:0]                         kind;
        logic signed [rcr_pkg::COORD_W-1:0] x;
        logic signed [rcr_pkg::COORD_W-1:0] y;
        logic signed [rcr_pkg::COORD_W-1:0] w;
        logic signed [rcr_pkg::COORD_W-1:0] h;
        logic [rcr_pkg::CHAR_W-1:0]         color;
        logic [rcr_pkg::IDX_W-1:0]          row;
        logic [rcr_pkg::IDX_W-1:0]          col;
    } command_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [103:0]                   s_tdata = '0;
    logic [9:0]                     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [15:0]                    m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [rcr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rcr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the block state
    logic [rcr_pkg::CHAR_W-1:0] shadow_canvas [0:65535];
    bit                         shadow_written [0:65535];
    bit                         error_flag = 1'b0;
    int                         canvas_cols = 256;
    int                         canvas_rows = 256;
    logic [rcr_pkg::CHAR_W-1:0] background = 8'd46;

    rcr_pkg::result_t pending_results [$];
    rcr_pkg::result_t got;
    rcr_pkg::result_t want;

    bit steady_flow = 1'b0;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;
    int stall_left = 0;
    int mismatches = 0;
    int results_checked = 0;
    int draws_sent = 0;
    int rejects_seen = 0;
    int clears_sent = 0;
    int reads_sent = 0;
    int reg_writes = 0;
    int input_stalls = 0;
    int cycle_count = 0;

    rectangle_canvas_rasterizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (s_tvalid && !s_tready)
            input_stalls++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            return 0;
        if (r < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    function automatic int fit_side(logic [rcr_pkg::SIDE_W-1:0] v);
        if (v == 0)
            return 1;
        if (int'(v) > SIDE)
            return SIDE;
        return int'(v);
    endfunction

    // Compute the result of one command and update the shadow canvas
    task automatic paint_and_answer(input command_t c);
        rcr_pkg::result_t ans;
        longint           x0, y0, x1, y1, px, py;
        bit               in_rect, border;
        int               r, k;
        ans = '0;
        case (c.cmd)
            rcr_pkg::CMD_DRAW:
            begin
                draws_sent++;
                if (c.w <= 0 || c.h <= 0 ||
                    !(c.kind == rcr_pkg::KIND_OUTLINE || c.kind == rcr_pkg::KIND_FILLED))
                begin
                    error_flag = 1'b1;
                    ans.status = rcr_pkg::STATUS_REJECT;
                    rejects_seen++;
                end
                else
                begin
                    x0 = longint'(c.x);
                    y0 = longint'(c.y);
                    x1 = x0 + longint'(c.w);
                    y1 = y0 + longint'(c.h);
                    for (r = 0; r < canvas_rows; r++)
                    begin
                        py = r * ONE_Q;
                        for (k = 0; k < canvas_cols; k++)
                        begin
                            px = k * ONE_Q;
                            in_rect = px >= x0 && px <= x1 && py >= y0 && py <= y1;
                            border = in_rect && (px - x0 < ONE_Q || x1 - px < ONE_Q ||
                                                 py - y0 < ONE_Q || y1 - py < ONE_Q);
                            if ((c.kind == rcr_pkg::KIND_OUTLINE && border) ||
                                (c.kind == rcr_pkg::KIND_FILLED && in_rect))
                            begin
                                shadow_canvas[r * SIDE + k] = c.color;
                                shadow_written[r * SIDE + k] = 1'b1;
                            end
                        end
                    end
                end
            end
            rcr_pkg::CMD_CLEAR:
            begin
                clears_sent++;
                for (r = 0; r < canvas_rows; r++)
                    for (k = 0; k < canvas_cols; k++)
                    begin
                        shadow_canvas[r * SIDE + k] = background;
                        shadow_written[r * SIDE + k] = 1'b1;
                    end
                error_flag = 1'b0;
            end
            rcr_pkg::CMD_READ:
            begin
                reads_sent++;
                if (int'(c.row) >= canvas_rows || int'(c.col) >= canvas_cols)
                    ans.status = rcr_pkg::STATUS_OUTSIDE;
                else
                    ans.pixel_value = shadow_canvas[{c.row, c.col}];
            end
            default:
                ;
        endcase
        ans.error_seen = error_flag;
        pending_results.push_back(ans);
    endtask

    function automatic command_t make_cmd(logic [1:0] cmd, logic [7:0] kind, int x, int y,
                                          int w, int h, logic [7:0] color,
                                          logic [7:0] row, logic [7:0] col);
        command_t c;
        c.cmd   = cmd;
        c.kind  = kind;
        c.x     = x[rcr_pkg::COORD_W-1:0];
        c.y     = y[rcr_pkg::COORD_W-1:0];
        c.w     = w[rcr_pkg::COORD_W-1:0];
        c.h     = h[rcr_pkg::COORD_W-1:0];
        c.color = color;
        c.row   = row;
        c.col   = col;
        return c;
    endfunction

    // Offer one command and wait until the block takes it
    task automatic push_command(input command_t c);
        int gap;
        // never read a pixel that no clear or draw has written
        if (c.cmd == rcr_pkg::CMD_READ && int'(c.row) < canvas_rows &&
            int'(c.col) < canvas_cols && !shadow_written[{c.row, c.col}])
        begin
            c.row = '0;
            c.col = '0;
        end
        gap = steady_flow ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {c.col, c.row, c.color, c.h, c.w, c.y, c.x};
        s_tuser  <= {c.kind, c.cmd};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        paint_and_answer(c);
    endtask

    task automatic write_register(input logic [rcr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [rcr_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            rcr_pkg::CFG_WIDTH:  canvas_cols = fit_side(value);
            rcr_pkg::CFG_HEIGHT: canvas_rows = fit_side(value);
            rcr_pkg::CFG_BG:     background = value[rcr_pkg::CHAR_W-1:0];
            default:    ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until every outstanding transaction has come back
    task automatic idle_wait();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_canvas(input int cols, input int rows, input logic [7:0] bg);
        idle_wait();
        write_register(rcr_pkg::CFG_WIDTH, cols[rcr_pkg::CFG_DATA_W-1:0]);
        write_register(rcr_pkg::CFG_HEIGHT, rows[rcr_pkg::CFG_DATA_W-1:0]);
        write_register(rcr_pkg::CFG_BG, {1'b0, bg});
    endtask

    function automatic command_t random_command();
        command_t c;
        int       sel;
        c.cmd   = rcr_pkg::CMD_DRAW;
        c.kind  = 8'($urandom);
        c.x     = rcr_pkg::COORD_W'($urandom);
        c.y     = rcr_pkg::COORD_W'($urandom);
        c.w     = rcr_pkg::COORD_W'($urandom);
        c.h     = rcr_pkg::COORD_W'($urandom);
        c.color = rcr_pkg::CHAR_W'($urandom);
        c.row   = rcr_pkg::IDX_W'($urandom);
        c.col   = rcr_pkg::IDX_W'($urandom);
        sel = int'($urandom_range(0, 99));
        if (sel < 40)
        begin
            c.kind = $urandom_range(0, 1) ? rcr_pkg::KIND_OUTLINE : rcr_pkg::KIND_FILLED;
            c.x = rcr_pkg::COORD_W'(int'($urandom_range(0, (canvas_cols + 5) * 256)) - 768);
            c.y = rcr_pkg::COORD_W'(int'($urandom_range(0, (canvas_rows + 5) * 256)) - 768);
            c.w = rcr_pkg::COORD_W'($urandom_range(1, (canvas_cols + 3) * 256));
            c.h = rcr_pkg::COORD_W'($urandom_range(1, (canvas_rows + 3) * 256));
        end
        else if (sel < 52)
        begin
            // broken or far-off shapes
            if ($urandom_range(0, 1))
                c.kind = $urandom_range(0, 1) ? rcr_pkg::KIND_OUTLINE : rcr_pkg::KIND_FILLED;
            if ($urandom_range(0, 1))
                c.w = rcr_pkg::COORD_W'(-int'($urandom_range(0, 2000)));
            else if ($urandom_range(0, 1))
                c.h = rcr_pkg::COORD_W'(-int'($urandom_range(0, 2000)));
        end
        else if (sel < 85)
        begin
            c.cmd = rcr_pkg::CMD_READ;
            if ($urandom_range(0, 4) != 0)
            begin
                c.row = rcr_pkg::IDX_W'($urandom_range(0, canvas_rows));
                c.col = rcr_pkg::IDX_W'($urandom_range(0, canvas_cols));
            end
        end
        else if (sel < 95)
            c.cmd = rcr_pkg::CMD_CLEAR;
        else
            c.cmd = CMD_UNUSED;
        return c;
    endfunction

    // Result side: random stalls, plus a long hold when a test asks for one
    always @(negedge clk)
    begin
        if (holds_done != holds_asked)
        begin
            holds_done = holds_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!steady_flow && $urandom_range(0, 3) == 0)
        begin
            stall_left = pick_gap();
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = rcr_pkg::result_t'(m_tdata[10:0]);
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected transaction, status %0d pixel %0d error_seen %0d",
                         $time, got.status, got.pixel_value, got.error_seen);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                end
                if (got.pixel_value !== want.pixel_value)
                begin
                    mismatches++;
                    $display("%0t: pixel_value expected %0d actual %0d",
                             $time, want.pixel_value, got.pixel_value);
                end
                if (got.error_seen !== want.error_seen)
                begin
                    mismatches++;
                    $display("%0t: error_seen expected %0d actual %0d",
                             $time, want.error_seen, got.error_seen);
                end
            end
        end
    end

    // Full 256 by 256 canvas as it comes out of reset
    task automatic test_default_canvas();
        push_command(make_cmd(rcr_pkg::CMD_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 8'd0, 8'd0));
        // fractional edges: columns 2..4, rows 3..4
        push_command(make_cmd(rcr_pkg::CMD_DRAW, rcr_pkg::KIND_FILLED, 384, 576, 768, 640,
                              "A", 8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_DRAW, rcr_pkg::KIND_OUTLINE, 0, 0, 255 * 256,
                              255 * 256, "B", 8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8'd3, 8'd2));
        push_command(make_cmd(rcr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8'd255, 8'd255));
        push_command(make_cmd(rcr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8'd128, 8'd128));
    endtask

    // Smallest canvas, widest single row and tallest single column
    task automatic test_config_extremes();
        set_canvas(0, 0, 8'h00);
        push_command(make_cmd(rcr_pkg::CMD_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8'd1, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_DRAW, rcr_pkg::KIND_FILLED, -128, -128, 256, 256,
                              8'hFF, 8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8'd0, 8'd0));
        set_canvas(511, 1, 8'hFF);
        push_command(make_cmd(rcr_pkg::CMD_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_DRAW, rcr_pkg::KIND_OUTLINE, 0, 0, 255 * 256, 128,
                              "r", 8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8'd0, 8'd255));
        push_command(make_cmd(rcr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8'd1, 8'd0));
        set_canvas(1, 511, 8'h80);
        push_command(make_cmd(rcr_pkg::CMD_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8'd255, 8'd0));
    endtask

    // Rejected shapes, sticky flag, unused command, sub-pixel and extreme rectangles
    task automatic test_special_cases();
        set_canvas(12, 10, "#");
        push_command(make_cmd(rcr_pkg::CMD_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_DRAW, rcr_pkg::KIND_FILLED, 0, 0, 0, 512, "z",
                              8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_DRAW, rcr_pkg::KIND_OUTLINE, 0, 0, 512, -256, "z",
                              8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_DRAW, "x", 0, 0, 512, 512, "z", 8'd0, 8'd0));
        // integer edges: the ring at distance exactly 1.0 counts as interior
        push_command(make_cmd(rcr_pkg::CMD_DRAW, rcr_pkg::KIND_FILLED, 512, 512, 1024, 768,
                              "F", 8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_DRAW, rcr_pkg::KIND_OUTLINE, 1280, 1280, 128, 128,
                              "s", 8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_DRAW, rcr_pkg::KIND_OUTLINE, -524288, -524288,
                              524287, 524287, "m", 8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_DRAW, rcr_pkg::KIND_FILLED, 524287, -256, 524287,
                              2048, "M", 8'd0, 8'd0));
        push_command(make_cmd(CMD_UNUSED, 8'hFF, -1, -1, -1, -1, 8'hFF, 8'hFF, 8'hFF));
        push_command(make_cmd(rcr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8'd3, 8'd3));
        push_command(make_cmd(rcr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8'd5, 8'd5));
        push_command(make_cmd(rcr_pkg::CMD_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 8'd0, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8'd10, 8'd0));
        push_command(make_cmd(rcr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8'd0, 8'd12));
    endtask

    // Hold the result side while commands keep coming, so the job queue fills up
    task automatic test_backpressure();
        idle_wait();
        steady_flow = 1'b1;
        holds_asked++;
        repeat (16) push_command(random_command());
        steady_flow = 1'b0;
    endtask

    task automatic run_random_phase(input int cols, input int rows, input int count);
        set_canvas(cols, rows, 8'($urandom));
        push_command(make_cmd(rcr_pkg::CMD_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 8'd0, 8'd0));
        repeat (count) push_command(random_command());
    endtask

    task automatic test_random_traffic();
        run_random_phase(16, 12, 15);
        steady_flow = 1'b1;
        run_random_phase(7, 20, 8);
        steady_flow = 1'b0;
        run_random_phase(int'($urandom_range(1, 24)), int'($urandom_range(1, 24)), 12);
        run_random_phase(64, 6, 10);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_default_canvas();
        test_config_extremes();
        test_special_cases();
        test_backpressure();
        test_random_traffic();
        idle_wait();
        repeat (20) @(posedge clk);
        $display("Sent %0d draws (%0d rejected), %0d clears, %0d reads, %0d register writes.",
                 draws_sent, rejects_seen, clears_sent, reads_sent, reg_writes);
        $display("Checked %0d results; input was held off for %0d cycles in total.",
                 results_checked, input_stalls);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
